// ===== hw/rtl/bras_pkg.sv =====
// shared constants, types and step functions for the bragg rotation angle solver
package bras_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 32;

	localparam int N_STAGES     = 134;
	localparam int CORDIC_STEPS = 30;

	localparam logic [7:0]  REG_ENERGY = 8'd0;
	localparam logic [7:0]  REG_CHI    = 8'd1;

	localparam logic [23:0] ENERGY_RST = 24'd3276800;
	localparam logic [56:0] KINV2      = 57'd4353147550;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

	localparam logic [31:0] ATAN_TAB [0:29] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic [31:0]        z;
	} vec_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	typedef struct packed {
		logic        q;
		logic [43:0] r;
	} dv_t;

	typedef struct packed {
		logic               bad;
		logic               sat;
		logic               vzneg;
		logic               azero;
		logic               bzero;
		logic               unobs;
		logic               obs;
		logic [43:0]        rs;
		logic [43:0]        ds;
		logic [43:0]        rc;
		logic [43:0]        dc;
		logic [31:0]        qs;
		logic [31:0]        qc;
		logic [32:0]        sint;
		logic signed [31:0] cchi;
		sq_t                sq;
		logic signed [66:0] p1;
		logic signed [66:0] p2;
		logic signed [34:0] num;
		logic signed [34:0] den;
		logic [34:0]        an;
		logic [34:0]        ad;
		vec_t               a;
		vec_t               b;
		logic [31:0]        d0;
		logic [31:0]        o1;
		logic [31:0]        o2;
	} item_t;

	// one restoring division step, two integer bits first
	function automatic dv_t div_step(logic [43:0] r, logic [43:0] d, int j);
		dv_t         res;
		logic [43:0] rr;
		logic [43:0] tt;
		if (j < 2) begin
			rr = r;
			tt = d << (1 - j);
		end else begin
			rr = r << 1;
			tt = d;
		end
		if (rr >= tt) begin
			res.q = 1'b1;
			res.r = rr - tt;
		end else begin
			res.q = 1'b0;
			res.r = rr;
		end
		return res;
	endfunction

	// one digit of the integer square root
	function automatic sq_t sqrt_step(sq_t a, int k);
		sq_t         res;
		logic [63:0] bt;
		bt = 64'd1 << (62 - 2 * k);
		if (a.v >= a.r + bt) begin
			res.v = a.v - (a.r + bt);
			res.r = (a.r >> 1) + bt;
		end else begin
			res.v = a.v;
			res.r = a.r >> 1;
		end
		return res;
	endfunction

	// one vectoring cordic iteration
	function automatic vec_t vec_step(vec_t a, int i);
		vec_t               res;
		logic signed [35:0] dx;
		logic signed [35:0] dy;
		dx = a.y >>> i;
		dy = a.x >>> i;
		if (a.y > 0) begin
			res.x = a.x + dx;
			res.y = a.y - dy;
			res.z = a.z + ATAN_TAB[i];
		end else begin
			res.x = a.x - dx;
			res.y = a.y + dy;
			res.z = a.z - ATAN_TAB[i];
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/bragg_rotation_angle_solver_core.sv =====
// bragg rotation angle solver: pipelined solver with a config-time sincos sequencer
// throughput: one word per cycle; a stalled output freezes the whole pipeline
// after reset and after every config write the input is held off
// while the wavenumber and the tilt sin/cos are computed
// arst_n clears all valid bits and loads the register reset values
module bragg_rotation_angle_solver_core #(
	parameter int FRAC_BITS  = bras_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS = bras_pkg::ANGLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // vec_x, vec_y, vec_z, vec_mag, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // omega_first, omega_second
	output logic [0:0]   m_axis_tuser,  // observable
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int N  = bras_pkg::N_STAGES;
	localparam int NW = 31 + 32 - FRAC_BITS;
	localparam int CW = (NW > 43) ? NW : 43;
	localparam logic [31:0] AMASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

	// config registers and sequencer
	logic [23:0]        energy_q;
	logic [31:0]        chi_q;
	logic               busy_q;
	logic [4:0]         cnt_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic [56:0]        acc_q;
	logic [40:0]        twok_q;
	logic signed [33:0] sl_q, cl_q;

	logic               cfg_we;
	logic [31:0]        chi_new;
	logic               flip_new;
	logic [31:0]        chi_fl;
	logic signed [33:0] z_init;
	logic signed [33:0] dx, dy, tab, cx_nx, cy_nx, cz_nx;
	logic [56:0]        acc_nx;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		chi_new  = (cfg_index == bras_pkg::REG_CHI) ? cfg_data : chi_q;
		flip_new = (chi_new[31:30] == 2'b01) || (chi_new[31:30] == 2'b10);
		chi_fl   = flip_new ? chi_new + bras_pkg::HALF_TURN : chi_new;
		z_init   = 34'(signed'(chi_fl));
		dx       = cy_q >>> cnt_q;
		dy       = cx_q >>> cnt_q;
		tab      = signed'({2'b00, bras_pkg::ATAN_TAB[cnt_q]});
		if (cz_q >= 0) begin
			cx_nx = cx_q - dx;
			cy_nx = cy_q + dy;
			cz_nx = cz_q - tab;
		end else begin
			cx_nx = cx_q + dx;
			cy_nx = cy_q - dy;
			cz_nx = cz_q + tab;
		end
		acc_nx = acc_q;
		if (cnt_q < 5'd24) begin
			if (energy_q[cnt_q]) begin
				acc_nx = acc_q + (bras_pkg::KINV2 << cnt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= bras_pkg::ENERGY_RST;
			chi_q    <= '0;
			busy_q   <= 1'b1;
			cnt_q    <= '0;
			cx_q     <= bras_pkg::GAIN_Q30;
			cy_q     <= '0;
			cz_q     <= '0;
			flip_q   <= 1'b0;
			acc_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bras_pkg::REG_ENERGY: energy_q <= cfg_data[23:0];
				bras_pkg::REG_CHI:    chi_q    <= cfg_data;
				default: ;
			endcase
			busy_q <= 1'b1;
			cnt_q  <= '0;
			cx_q   <= bras_pkg::GAIN_Q30;
			cy_q   <= '0;
			cz_q   <= z_init;
			flip_q <= flip_new;
			acc_q  <= '0;
		end else if (busy_q) begin
			cx_q  <= cx_nx;
			cy_q  <= cy_nx;
			cz_q  <= cz_nx;
			acc_q <= acc_nx;
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd29) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg_we && busy_q && cnt_q == 5'd29) begin
			twok_q <= 41'(acc_nx >> 16);
			sl_q   <= flip_q ? -cy_nx : cy_nx;
			cl_q   <= flip_q ? -cx_nx : cx_nx;
		end
	end

	// item pipeline
	logic            adv;
	logic [N:1]      vld_s;
	bras_pkg::item_t stage_s [1:N];
	bras_pkg::item_t in_item;

	assign adv           = !vld_s[N] || m_axis_tready;
	assign s_axis_tready = adv && !busy_q;

	always_comb begin
		logic [30:0]        mag;
		logic signed [31:0] vx, vy, vz;
		logic [31:0]        azv;
		logic [CW-1:0]      n_ext;
		logic [CW-1:0]      d4;
		vx    = signed'(s_axis_tdata[31:0]);
		vy    = signed'(s_axis_tdata[63:32]);
		vz    = signed'(s_axis_tdata[95:64]);
		mag   = s_axis_tdata[126:96];
		azv   = vz[31] ? 32'(-vz) : 32'(vz);
		n_ext = CW'(mag) << (32 - FRAC_BITS);
		d4    = CW'({twok_q, 2'b00});
		in_item       = '0;
		in_item.bad   = (mag == '0) || (twok_q == '0) || (azv > {1'b0, mag});
		in_item.sat   = n_ext >= d4;
		in_item.vzneg = vz[31];
		in_item.rs    = 44'(n_ext);
		in_item.ds    = 44'(twok_q);
		in_item.rc    = 44'(azv);
		in_item.dc    = 44'(mag);
		in_item.azero = (vx == '0) && (vy == '0);
		in_item.a.x   = 36'(vy);
		in_item.a.y   = 36'(vx);
		in_item.a.z   = '0;
		if (in_item.a.x < 0) begin
			in_item.a.x = -in_item.a.x;
			in_item.a.y = -in_item.a.y;
			in_item.a.z = bras_pkg::HALF_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-1:1], s_axis_tvalid && s_axis_tready};
		end
	end

	for (genvar s = 1; s <= N; s++) begin : g_st
		bras_pkg::item_t src;
		bras_pkg::item_t nxt;

		if (s == 1) begin : g_first
			assign src = in_item;
		end else begin : g_next
			assign src = stage_s[s-1];
		end

		always_comb begin
			bras_pkg::dv_t      ds, dc;
			logic [61:0]        sq;
			logic signed [32:0] schi;
			logic signed [34:0] sn;
			logic [63:0]        a2, n2;
			logic [31:0]        bz;
			nxt = src;
			if (s >= 2 && s <= 33) begin
				ds      = bras_pkg::div_step(src.rs, src.ds, s - 2);
				dc      = bras_pkg::div_step(src.rc, src.dc, s - 2);
				nxt.rs  = ds.r;
				nxt.rc  = dc.r;
				nxt.qs  = {src.qs[30:0], ds.q};
				nxt.qc  = {src.qc[30:0], dc.q};
			end
			if (s >= 2 && s <= 31) begin
				nxt.a = bras_pkg::vec_step(src.a, s - 2);
			end
			if (s == 34) begin
				nxt.sint = src.sat ? 33'h1_0000_0000 : {1'b0, src.qs};
				nxt.cchi = src.vzneg ? -signed'(src.qc) : signed'(src.qc);
				sq       = src.qc[30:0] * src.qc[30:0];
				nxt.sq.v = (64'd1 << 60) - 64'(sq);
				nxt.sq.r = '0;
				nxt.d0   = src.azero ? '0 : src.a.z;
			end
			if (s >= 35 && s <= 66) begin
				nxt.sq = bras_pkg::sqrt_step(src.sq, s - 35);
			end
			if (s == 67) begin
				schi   = signed'({1'b0, src.sq.r[31:0]});
				nxt.p1 = src.cchi * sl_q;
				nxt.p2 = schi * cl_q;
			end
			if (s == 68) begin
				nxt.num = signed'({2'b00, src.sint}) + 35'(src.p1 >>> 30);
				nxt.den = 35'(src.p2 >>> 30);
			end
			if (s == 69) begin
				nxt.an    = src.num[34] ? 35'(-src.num) : 35'(src.num);
				nxt.ad    = src.den[34] ? 35'(-src.den) : 35'(src.den);
				nxt.unobs = nxt.an > nxt.ad;
				sn        = src.den[34] ? -src.num : src.num;
				nxt.b.y   = 36'(sn);
			end
			if (s == 70) begin
				a2       = src.ad[31:0] * src.ad[31:0];
				n2       = src.an[31:0] * src.an[31:0];
				nxt.sq.v = a2 - n2;
				nxt.sq.r = '0;
			end
			if (s >= 71 && s <= 102) begin
				nxt.sq = bras_pkg::sqrt_step(src.sq, s - 71);
			end
			if (s == 103) begin
				nxt.b.x   = signed'({4'b0000, src.sq.r[31:0]});
				nxt.b.z   = '0;
				nxt.bzero = (src.b.y == '0) && (src.sq.r[31:0] == '0);
			end
			if (s >= 104 && s <= 133) begin
				nxt.b = bras_pkg::vec_step(src.b, s - 104);
			end
			if (s == 134) begin
				bz = src.bzero ? '0 : src.b.z;
				if (src.bad || src.unobs) begin
					nxt.obs = 1'b0;
					nxt.o1  = '0;
					nxt.o2  = '0;
				end else begin
					nxt.obs = 1'b1;
					nxt.o1  = (bz + src.d0) & AMASK;
					nxt.o2  = (bras_pkg::HALF_TURN - bz + src.d0) & AMASK;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_s[s] <= nxt;
			end
		end
	end

	assign m_axis_tvalid   = vld_s[N];
	assign m_axis_tdata    = {stage_s[N].o2, stage_s[N].o1};
	assign m_axis_tuser[0] = stage_s[N].obs;

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy_q)
		else $error("sequencer not restarted after config write");

	a_unobs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("unobservable word carries nonzero angles");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= 5'd29)
		else $error("sequencer step count out of range");

endmodule
